@@ sv/mgi_pkg.sv @@
// ---------------------------------------------------------------------------
// mgi_pkg: shared types and constants
// Operation codes, register indexes, state types and the merge result struct
// for the multilinear grid interpolator.
// ---------------------------------------------------------------------------
package mgi_pkg;

    localparam int COORD_FIELDS = 4;
    localparam int WEIGHT_W     = 17;
    localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

    typedef enum logic [1:0] {
        OP_LOAD_TICK = 2'd0,
        OP_LOAD_GRID = 2'd1,
        OP_QUERY     = 2'd2,
        OP_UNUSED    = 2'd3
    } t_op;

    localparam logic [2:0] REG_NUM_DIMS   = 3'd0;
    localparam logic [2:0] REG_AXIS_LEN_0 = 3'd1;
    localparam logic [2:0] REG_AXIS_LEN_1 = 3'd2;
    localparam logic [2:0] REG_AXIS_LEN_2 = 3'd3;
    localparam logic [2:0] REG_AXIS_LEN_3 = 3'd4;

    typedef enum logic [2:0] {
        L_IDLE, L_END, L_CHK, L_SRD, L_SCMP, L_DIV, L_DONE
    } t_lane_state;

    typedef enum logic [2:0] {
        M_IDLE, M_FAC, M_RD, M_MUL, M_ACC, M_DONE
    } t_merge_state;

    typedef enum logic [1:0] {
        Q_IDLE, Q_LANES, Q_MERGE
    } t_top_state;

    typedef struct packed {
        logic        valid;
        logic        sat;
        logic [31:0] value;
    } t_merge_res;

endpackage

@@ sv/multilinear_grid_interpolator.sv @@
// ---------------------------------------------------------------------------
// multilinear_grid_interpolator: top level
// Config registers, item dispatch, per-axis search lanes, corner merge and
// the output register.
// ---------------------------------------------------------------------------
//  channel  | dir | tdata                                   | tuser
//  s_*      | in  | load_addr, load_value, coord_0..coord_3 | operation, axis_sel
//  m_*      | out | interp_value                            | saturated
//  APB      | in  | num_dims, axis_len_0..3 at 0x0..0x10    | -
//
// A query runs in the axis lanes (binary search plus a restoring divide, all
// axes in parallel) and then walks the 2^d corners of the cell in the merge
// unit. Reset is synchronous; stores are not cleared. s_tready is low while a
// query is in flight; a waiting result sits in the output register.
// ---------------------------------------------------------------------------
module multilinear_grid_interpolator #(
    parameter int MAX_DIMS        = 4,
    parameter int MAX_AXIS_POINTS = 8,
    parameter int GRID_ENTRIES    = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [175:0] s_tdata,   // load_addr, load_value, coord_0..coord_3
    input  logic [3:0]   s_tuser,   // operation, axis_sel
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // interp_value
    output logic         m_tuser,   // saturated
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import mgi_pkg::*;

    localparam int LANES = (MAX_DIMS < COORD_FIELDS) ? MAX_DIMS : COORD_FIELDS;
    localparam int AW    = $clog2(MAX_AXIS_POINTS);
    localparam int LW    = $clog2(MAX_AXIS_POINTS + 1);
    localparam int GAW   = $clog2(GRID_ENTRIES);

    logic [2:0] r_num_dims;
    logic [3:0] r_len [COORD_FIELDS];
    logic [2:0] reg_idx;
    logic       cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= 3'd1;
            for (int a = 0; a < COORD_FIELDS; a++) r_len[a] <= 4'd1;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_NUM_DIMS:   r_num_dims <= pwdata[2:0];
                REG_AXIS_LEN_0: r_len[0]   <= pwdata[3:0];
                REG_AXIS_LEN_1: r_len[1]   <= pwdata[3:0];
                REG_AXIS_LEN_2: r_len[2]   <= pwdata[3:0];
                REG_AXIS_LEN_3: r_len[3]   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NUM_DIMS:   prdata = {29'd0, r_num_dims};
            REG_AXIS_LEN_0: prdata = {28'd0, r_len[0]};
            REG_AXIS_LEN_1: prdata = {28'd0, r_len[1]};
            REG_AXIS_LEN_2: prdata = {28'd0, r_len[2]};
            REG_AXIS_LEN_3: prdata = {28'd0, r_len[3]};
            default:        prdata = '0;
        endcase
    end

    // clamped dimension count and axis lengths
    logic [2:0]    dims;
    logic [LW-1:0] len_c [LANES];

    always_comb begin
        if (r_num_dims == 3'd0) dims = 3'd1;
        else if (int'(r_num_dims) > LANES) dims = 3'(LANES);
        else dims = r_num_dims;
        for (int a = 0; a < LANES; a++) begin
            if (r_len[a] == 4'd0) len_c[a] = LW'(1);
            else if (int'(r_len[a]) > MAX_AXIS_POINTS) len_c[a] = LW'(MAX_AXIS_POINTS);
            else len_c[a] = LW'(r_len[a]);
        end
    end

    // item fields
    t_op         op;
    logic [1:0]  axis_sel;
    logic [11:0] load_addr;
    logic [31:0] load_value;
    logic        acc;

    assign op         = t_op'(s_tuser[1:0]);
    assign axis_sel   = s_tuser[3:2];
    assign load_addr  = s_tdata[11:0];
    assign load_value = s_tdata[43:12];
    assign acc        = s_tvalid && s_tready;

    t_top_state r_state, n_state;
    logic       query_go, merge_go, all_done;
    logic [LANES-1:0] lane_done;

    logic [AW-1:0]        lane_node [LANES];
    logic [WEIGHT_W-1:0]  lane_w    [LANES];
    t_merge_res           mres;

    assign query_go = acc && (op == OP_QUERY);
    assign s_tready = (r_state == Q_IDLE);

    for (genvar a = 0; a < LANES; a++) begin : g_lane
        logic tick_wr;
        assign tick_wr = acc && (op == OP_LOAD_TICK) && (axis_sel == 2'(a)) &&
                         (32'(load_addr) < 32'(MAX_AXIS_POINTS));
        mgi_axis_lane #(
            .MAX_AXIS_POINTS(MAX_AXIS_POINTS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (tick_wr),
            .i_wr_addr (AW'(load_addr)),
            .i_wr_data (load_value),
            .i_start   (query_go && (a < int'(dims))),
            .i_x       (s_tdata[44 + 32*a +: 32]),
            .i_len     (len_c[a]),
            .o_done    (lane_done[a]),
            .o_node    (lane_node[a]),
            .o_weight  (lane_w[a])
        );
    end

    always_comb begin
        all_done = 1'b1;
        for (int a = 0; a < LANES; a++) begin
            if (a < int'(dims) && !lane_done[a]) all_done = 1'b0;
        end
    end

    assign merge_go = (r_state == Q_LANES) && all_done;

    mgi_merge #(
        .MAX_AXIS_POINTS(MAX_AXIS_POINTS),
        .GRID_ENTRIES   (GRID_ENTRIES),
        .LANES          (LANES)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (acc && (op == OP_LOAD_GRID) && (32'(load_addr) < 32'(GRID_ENTRIES))),
        .i_wr_addr (GAW'(load_addr)),
        .i_wr_data (load_value),
        .i_start   (merge_go),
        .i_dims    (dims),
        .i_len     (len_c),
        .i_node    (lane_node),
        .i_weight  (lane_w),
        .o_res     (mres)
    );

    logic        r_m_valid;
    logic [31:0] r_m_data;
    logic        r_m_sat;
    logic        out_load;

    assign out_load = (r_state == Q_MERGE) && mres.valid && (!r_m_valid || m_tready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            Q_IDLE:  if (query_go) n_state = Q_LANES;
            Q_LANES: if (all_done) n_state = Q_MERGE;
            Q_MERGE: if (out_load) n_state = Q_IDLE;
            default: n_state = Q_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= Q_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) r_m_valid <= 1'b1;
            else if (m_tready) r_m_valid <= 1'b0;
        end
        if (out_load) begin
            r_m_data <= mres.value;
            r_m_sat  <= mres.sat;
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;
    assign m_tuser  = r_m_sat;

endmodule

@@ sv/mgi_axis_lane.sv @@
// ---------------------------------------------------------------------------
// mgi_axis_lane: per-axis cell search
// Holds one axis's tick table, clamps the query coordinate, runs a binary
// search with a read state and a compare state per probe, and a 16-step
// restoring divide for the lower node weight.
// ---------------------------------------------------------------------------
module mgi_axis_lane #(
    parameter int MAX_AXIS_POINTS = 8,
    parameter int AW = $clog2(MAX_AXIS_POINTS),
    parameter int LW = $clog2(MAX_AXIS_POINTS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic signed [31:0]          i_wr_data,
    input  logic                        i_start,
    input  logic signed [31:0]          i_x,
    input  logic [LW-1:0]               i_len,
    output logic                        o_done,
    output logic [AW-1:0]               o_node,
    output logic [mgi_pkg::WEIGHT_W-1:0] o_weight
);
    import mgi_pkg::*;

    localparam int SW = AW + 2;

    logic signed [31:0] mem [MAX_AXIS_POINTS];
    logic signed [31:0] r_ta, r_tb, r_x;
    logic [AW-1:0]      rd_a, rd_b;

    t_lane_state r_state, n_state;
    logic signed [SW-1:0] r_lo, r_hi, r_mid, n_lo, n_hi, n_mid;
    logic [AW-1:0]        r_node, n_node;
    logic [WEIGHT_W-1:0]  r_w, n_w;
    logic [32:0]          r_rem, n_rem, r_den, n_den;
    logic [15:0]          r_q, n_q;
    logic [3:0]           r_cnt, n_cnt;

    logic signed [SW-1:0] s_lo, s_hi;
    logic signed [SW:0]   sum_lh;
    logic [33:0]          sh;
    logic signed [32:0]   diff_num, diff_den;

    always_comb begin
        if (r_state == L_END) begin
            rd_a = '0;
            rd_b = AW'(i_len - LW'(1));
        end else begin
            rd_a = AW'(r_mid);
            rd_b = AW'(r_mid + SW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_ta <= mem[rd_a];
        r_tb <= mem[rd_b];
        if (i_start) begin
            r_x <= i_x;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_node   = r_node;
        n_w      = r_w;
        n_rem    = r_rem;
        n_den    = r_den;
        n_q      = r_q;
        n_cnt    = r_cnt;
        s_lo     = r_lo;
        s_hi     = r_hi;
        sum_lh   = '0;
        sh       = {r_rem, 1'b0};
        diff_num = $signed({r_tb[31], r_tb}) - $signed({r_x[31], r_x});
        diff_den = $signed({r_tb[31], r_tb}) - $signed({r_ta[31], r_ta});
        unique case (r_state)
            L_IDLE, L_DONE: begin
                if (i_start) n_state = L_END;
            end
            L_END: n_state = L_CHK;
            L_CHK: begin
                if (i_len == LW'(1) || r_x <= r_ta) begin
                    n_node  = '0;
                    n_w     = ONE_Q16;
                    n_state = L_DONE;
                end else if (r_x >= r_tb) begin
                    n_node  = AW'(i_len - LW'(1));
                    n_w     = ONE_Q16;
                    n_state = L_DONE;
                end else begin
                    n_lo    = '0;
                    n_hi    = $signed(SW'(i_len)) - SW'(2);
                    sum_lh  = {n_hi[SW-1], n_hi};
                    n_mid   = SW'(sum_lh >>> 1);
                    n_state = L_SRD;
                end
            end
            L_SRD: n_state = L_SCMP;
            L_SCMP: begin
                if (r_x < r_ta) begin
                    s_hi = r_mid - SW'(1);
                end else if (r_x >= r_tb) begin
                    s_lo = r_mid + SW'(1);
                end
                if (r_x >= r_ta && r_x < r_tb) begin
                    n_node = AW'(r_mid);
                    if (r_x == r_ta) begin
                        // on the lower tick: full weight, quotient would need bit 16
                        n_w     = ONE_Q16;
                        n_state = L_DONE;
                    end else begin
                        n_rem   = 33'(diff_num);
                        n_den   = 33'(diff_den);
                        n_q     = '0;
                        n_cnt   = '0;
                        n_state = L_DIV;
                    end
                end else if (s_lo > s_hi) begin
                    // search ran out without a cell: all weight on upper node
                    n_node  = AW'(r_mid);
                    n_w     = '0;
                    n_state = L_DONE;
                end else begin
                    n_lo    = s_lo;
                    n_hi    = s_hi;
                    sum_lh  = $signed({s_lo[SW-1], s_lo}) + $signed({s_hi[SW-1], s_hi});
                    n_mid   = SW'(sum_lh >>> 1);
                    n_state = L_SRD;
                end
            end
            L_DIV: begin
                if (sh >= {1'b0, r_den}) begin
                    n_rem = 33'(sh - {1'b0, r_den});
                    n_q   = {r_q[14:0], 1'b1};
                end else begin
                    n_rem = sh[32:0];
                    n_q   = {r_q[14:0], 1'b0};
                end
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    n_w     = {1'b0, n_q};
                    n_state = L_DONE;
                end
            end
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo   <= n_lo;
        r_hi   <= n_hi;
        r_mid  <= n_mid;
        r_node <= n_node;
        r_w    <= n_w;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
        r_cnt  <= n_cnt;
    end

    assign o_done   = (r_state == L_DONE);
    assign o_node   = r_node;
    assign o_weight = r_w;

endmodule

@@ sv/mgi_merge.sv @@
// ---------------------------------------------------------------------------
// mgi_merge: corner accumulation
// Holds the grid store. Walks the corners of the cell, forms each corner's
// weight product one axis a cycle, reads the grid value and accumulates,
// then floors and saturates the sum.
// ---------------------------------------------------------------------------
module mgi_merge #(
    parameter int MAX_AXIS_POINTS = 8,
    parameter int GRID_ENTRIES    = 4096,
    parameter int LANES           = 4,
    parameter int AW  = $clog2(MAX_AXIS_POINTS),
    parameter int LW  = $clog2(MAX_AXIS_POINTS + 1),
    parameter int GAW = $clog2(GRID_ENTRIES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [GAW-1:0]               i_wr_addr,
    input  logic signed [31:0]           i_wr_data,
    input  logic                         i_start,
    input  logic [2:0]                   i_dims,
    input  logic [LW-1:0]                i_len    [LANES],
    input  logic [AW-1:0]                i_node   [LANES],
    input  logic [mgi_pkg::WEIGHT_W-1:0] i_weight [LANES],
    output mgi_pkg::t_merge_res          o_res
);
    import mgi_pkg::*;

    localparam int AXW  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int FW   = LANES * AW + 1;
    localparam int SUMW = 56;

    logic signed [31:0] mem [GRID_ENTRIES];

    t_merge_state r_state, n_state;
    logic [LANES:0]          r_corner, n_corner;
    logic [AXW-1:0]          r_ax, n_ax;
    logic [WEIGHT_W-1:0]     r_f, n_f;
    logic [FW-1:0]           r_flat, n_flat;
    logic signed [31:0]      r_gv;
    logic                    r_use;
    logic signed [49:0]      r_prod;
    logic signed [SUMW-1:0]  r_sum, n_sum;

    logic                    cbit;
    logic [AW:0]             idx;
    logic [WEIGHT_W-1:0]     wa;
    logic [33:0]             fprod;
    logic                    in_range;
    logic [LANES:0]          last_corner;
    logic signed [SUMW-17:0] q;

    assign in_range    = 64'(r_flat) < 64'(GRID_ENTRIES);
    assign last_corner = (LANES+1)'((1 << i_dims) - 1);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_gv <= mem[GAW'(r_flat)];
    end

    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        n_ax     = r_ax;
        n_f      = r_f;
        n_flat   = r_flat;
        n_sum    = r_sum;
        cbit     = r_corner[r_ax];
        idx      = cbit ? {1'b0, i_node[r_ax]} : ({1'b0, i_node[r_ax]} + (AW+1)'(1));
        wa       = cbit ? i_weight[r_ax] : (ONE_Q16 - i_weight[r_ax]);
        fprod    = 34'(r_f) * 34'(wa);
        unique case (r_state)
            M_IDLE, M_DONE: begin
                if (i_start) begin
                    n_corner = '0;
                    n_ax     = '0;
                    n_f      = ONE_Q16;
                    n_flat   = '0;
                    n_sum    = '0;
                    n_state  = M_FAC;
                end
            end
            M_FAC: begin
                n_f    = fprod[32:16];
                n_flat = FW'(r_flat * FW'(i_len[r_ax])) + FW'(idx);
                n_ax   = r_ax + AXW'(1);
                if (r_ax == AXW'(i_dims - 3'd1)) n_state = M_RD;
            end
            M_RD:  n_state = M_MUL;
            M_MUL: n_state = M_ACC;
            M_ACC: begin
                n_sum = r_sum + {{(SUMW-50){r_prod[49]}}, r_prod};
                if (r_corner == last_corner) begin
                    n_state = M_DONE;
                end else begin
                    n_corner = r_corner + (LANES+1)'(1);
                    n_ax     = '0;
                    n_f      = ONE_Q16;
                    n_flat   = '0;
                    n_state  = M_FAC;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_corner <= n_corner;
        r_ax     <= n_ax;
        r_f      <= n_f;
        r_flat   <= n_flat;
        r_sum    <= n_sum;
        if (r_state == M_RD) begin
            // zero-factor corners and corners past the store add nothing
            r_use <= (r_f != '0) && in_range;
        end
        r_prod <= $signed({1'b0, r_f}) * (r_use ? r_gv : 32'sd0);
    end

    always_comb begin
        q           = r_sum[SUMW-1:16];
        o_res.valid = (r_state == M_DONE);
        o_res.sat   = 1'b0;
        o_res.value = q[31:0];
        if (!q[SUMW-17] && (|q[SUMW-18:31])) begin
            o_res.sat   = 1'b1;
            o_res.value = 32'h7fff_ffff;
        end else if (q[SUMW-17] && !(&q[SUMW-18:31])) begin
            o_res.sat   = 1'b1;
            o_res.value = 32'h8000_0000;
        end
    end

endmodule

@@ sv/mgi_checker.sv @@
// ---------------------------------------------------------------------------
// mgi_checker: port-level checks
// Watches the interpolator's ports and flags output, busy and config slips.
// ---------------------------------------------------------------------------
module mgi_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [3:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [31:0]  m_tdata,
    input logic         m_tuser,
    input logic         pready
);
    import mgi_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)
        else $error("saturated flag without a clipped value");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("block not idle after reset");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && s_tuser[1:0] == OP_QUERY |=> !s_tready)
        else $error("input taken while a query is in flight");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("config port not ready");

endmodule

bind multilinear_grid_interpolator mgi_checker u_mgi_checker (.*);
